/* design/gasg_pkg.sv */
// gasg_pkg: shared types, codes and reset constants for the altitude stability gate
// used by every module of the gnss_altitude_stability_gate_unit; no dependencies
package gasg_pkg;

	localparam int TIME_BITS_DEFAULT   = 32;
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	localparam int ALT_W    = 25;
	localparam int NOW_W    = 32;
	localparam int SATS_W   = 6;
	localparam int AGE_W    = 16;
	localparam int SPREAD_W = 16;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [ALT_W-1:0] ALT_TOP    = {1'b0, {(ALT_W-1){1'b1}}};
	localparam logic signed [ALT_W-1:0] ALT_BOTTOM = {1'b1, {(ALT_W-1){1'b0}}};

	localparam logic [SATS_W-1:0] BASIC_SATS = 6'd4;

	localparam logic [SATS_W-1:0]   MIN_SATS_RESET   = 6'd6;
	localparam logic [31:0]         WARMUP_RESET     = 32'd8000;
	localparam logic [31:0]         WINDOW_RESET     = 32'd4000;
	localparam logic [SPREAD_W-1:0] MAX_SPREAD_RESET = 16'd800;
	localparam logic [AGE_W-1:0]    MAX_AGE_RESET    = 16'd3000;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_SATS   = 3'd0,
		REG_WARMUP     = 3'd1,
		REG_WINDOW     = 3'd2,
		REG_MAX_SPREAD = 3'd3,
		REG_MAX_AGE    = 3'd4
	} cfg_reg_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_LOC_BAD    = 3'd1,
		ST_FEW_SATS   = 3'd2,
		ST_ALT_BAD    = 3'd3,
		ST_WARMING    = 3'd4,
		ST_SPREAD_BIG = 3'd5,
		ST_CLEARED    = 3'd6
	} status_t;

	// outcome of the front classification, carried through the queue
	typedef enum logic [2:0] {
		KIND_EVAL     = 3'd0,
		KIND_CLEAR    = 3'd1,
		KIND_LOC_BAD  = 3'd2,
		KIND_FEW_SATS = 3'd3,
		KIND_ALT_BAD  = 3'd4
	} item_kind_t;

	localparam int KIND_W = $bits(item_kind_t);

	typedef struct packed {
		logic [SATS_W-1:0]   min_sats;
		logic [31:0]         warmup_ms;
		logic [31:0]         window_ms;
		logic [SPREAD_W-1:0] max_spread_cm;
		logic [AGE_W-1:0]    max_age_ms;
	} cfg_t;

endpackage

/* design/gasg_front.sv */
// gasg_front: accepts input transactions and classifies each one before the queue
// depends on gasg_pkg
module gasg_front #(
	parameter int TIME_BITS = gasg_pkg::TIME_BITS_DEFAULT
) (
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             operation,
	input  logic [gasg_pkg::NOW_W-1:0]       now_ms,
	input  logic                             location_valid,
	input  logic [gasg_pkg::AGE_W-1:0]       location_age_ms,
	input  logic                             altitude_valid,
	input  logic [gasg_pkg::AGE_W-1:0]       altitude_age_ms,
	input  logic                             sats_valid,
	input  logic [gasg_pkg::SATS_W-1:0]      sat_count,
	input  logic signed [gasg_pkg::ALT_W-1:0] altitude_cm,
	input  gasg_pkg::cfg_t                   cfg,
	input  logic                             q_full,
	output logic                             q_push,
	output gasg_pkg::item_kind_t             q_kind,
	output logic [TIME_BITS-1:0]             q_now,
	output logic signed [gasg_pkg::ALT_W-1:0] q_alt
);
	import gasg_pkg::*;

	localparam int EXT_W = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

	logic              loc_ok;
	logic              alt_ok;
	logic [SATS_W-1:0] sats;
	logic              sats_low;
	logic [EXT_W-1:0]  now_ext;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	assign loc_ok   = location_valid && (location_age_ms <= cfg.max_age_ms);
	assign alt_ok   = altitude_valid && (altitude_age_ms <= cfg.max_age_ms);
	assign sats     = sats_valid ? sat_count : '0;
	assign sats_low = (sats < BASIC_SATS) || (sats < cfg.min_sats);

	// time kept modulo 2^TIME_BITS
	assign now_ext = EXT_W'(now_ms);
	assign q_now   = now_ext[TIME_BITS-1:0];
	assign q_alt   = altitude_cm;

	always_comb begin
		if (operation) begin
			q_kind = KIND_CLEAR;
		end else if (!loc_ok) begin
			q_kind = KIND_LOC_BAD;
		end else if (sats_low) begin
			q_kind = KIND_FEW_SATS;
		end else if (!alt_ok) begin
			q_kind = KIND_ALT_BAD;
		end else begin
			q_kind = KIND_EVAL;
		end
	end

endmodule

/* design/gasg_queue.sv */
// gasg_queue: short first-in first-out queue between the classifying front and the tracker
// depends on gasg_pkg only for the default depth
module gasg_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = gasg_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              pop_valid,
	output logic [DATA_W-1:0] pop_data
);
	import gasg_pkg::*;

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] entry_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CNTW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == CNTW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(DEPTH))
		else $error("queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + CNTW'(1)))
		else $error("queue count missed a push");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");

endmodule

/* design/gasg_back.sv */
// gasg_back: altitude tracker state, window and warm-up timing, spread check and result register
// depends on gasg_pkg
module gasg_back #(
	parameter int TIME_BITS = gasg_pkg::TIME_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gasg_pkg::cfg_t                    cfg,
	input  logic                              q_valid,
	input  gasg_pkg::item_kind_t              q_kind,
	input  logic [TIME_BITS-1:0]              q_now,
	input  logic signed [gasg_pkg::ALT_W-1:0] q_alt,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              fix_ok,
	output gasg_pkg::status_t                 status
);
	import gasg_pkg::*;

	localparam int EXT_W = (TIME_BITS > 32) ? TIME_BITS : 32;

	// tracker state
	logic                    fix_seen_q;
	logic [TIME_BITS-1:0]    first_q;
	logic [TIME_BITS-1:0]    win_start_q;
	logic signed [ALT_W-1:0] min_q;
	logic signed [ALT_W-1:0] max_q;

	// first stage: status plus the updated extremes for the spread check
	logic                    valid_s1;
	status_t                 status_s1;
	logic                    check_s1;
	logic signed [ALT_W-1:0] min_s1;
	logic signed [ALT_W-1:0] max_s1;

	logic    out_valid_q;
	logic    fix_q;
	status_t status_q;

	logic                    out_ready;
	logic                    s1_ready;
	logic [TIME_BITS-1:0]    eff_first;
	logic [TIME_BITS-1:0]    eff_win;
	logic signed [ALT_W-1:0] eff_min;
	logic signed [ALT_W-1:0] eff_max;
	logic [TIME_BITS-1:0]    warm_elapsed;
	logic [TIME_BITS-1:0]    win_elapsed;
	logic                    warming;
	logic                    restart;
	logic signed [ALT_W-1:0] base_min;
	logic signed [ALT_W-1:0] base_max;
	logic signed [ALT_W-1:0] new_min;
	logic signed [ALT_W-1:0] new_max;
	logic [ALT_W:0]          spread;
	logic                    spread_ok;

	assign out_ready = !out_valid_q || !out_stall;
	assign s1_ready  = !valid_s1 || out_ready;
	assign q_pop     = q_valid && s1_ready;

	// a first passing fix starts both timers at the current time
	assign eff_first = fix_seen_q ? first_q     : q_now;
	assign eff_win   = fix_seen_q ? win_start_q : q_now;
	assign eff_min   = fix_seen_q ? min_q       : ALT_TOP;
	assign eff_max   = fix_seen_q ? max_q       : ALT_BOTTOM;

	assign warm_elapsed = q_now - eff_first;
	assign win_elapsed  = q_now - eff_win;
	assign warming = EXT_W'(warm_elapsed) < EXT_W'(cfg.warmup_ms);
	assign restart = EXT_W'(win_elapsed) > EXT_W'(cfg.window_ms);

	assign base_min = restart ? ALT_TOP    : eff_min;
	assign base_max = restart ? ALT_BOTTOM : eff_max;
	assign new_min  = (q_alt < base_min) ? q_alt : base_min;
	assign new_max  = (q_alt > base_max) ? q_alt : base_max;

	// extremes always bracket the latest altitude, so the spread is never negative
	assign spread    = (ALT_W+1)'(max_s1) - (ALT_W+1)'(min_s1);
	assign spread_ok = spread <= (ALT_W+1)'(cfg.max_spread_cm);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_seen_q  <= 1'b0;
			first_q     <= '0;
			win_start_q <= '0;
			min_q       <= ALT_TOP;
			max_q       <= ALT_BOTTOM;
		end else if (q_pop) begin
			case (q_kind)
				KIND_CLEAR: begin
					fix_seen_q  <= 1'b0;
					first_q     <= '0;
					win_start_q <= '0;
					min_q       <= ALT_TOP;
					max_q       <= ALT_BOTTOM;
				end
				KIND_EVAL: begin
					fix_seen_q <= 1'b1;
					first_q    <= eff_first;
					if (warming) begin
						win_start_q <= eff_win;
						min_q       <= eff_min;
						max_q       <= eff_max;
					end else begin
						win_start_q <= restart ? q_now : eff_win;
						min_q       <= new_min;
						max_q       <= new_max;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			check_s1 <= (q_kind == KIND_EVAL) && !warming;
			min_s1   <= new_min;
			max_s1   <= new_max;
			case (q_kind)
				KIND_CLEAR:    status_s1 <= ST_CLEARED;
				KIND_LOC_BAD:  status_s1 <= ST_LOC_BAD;
				KIND_FEW_SATS: status_s1 <= ST_FEW_SATS;
				KIND_ALT_BAD:  status_s1 <= ST_ALT_BAD;
				KIND_EVAL:     status_s1 <= warming ? ST_WARMING : ST_OK;
				default:       status_s1 <= ST_CLEARED;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s1) begin
			if (check_s1) begin
				fix_q    <= spread_ok;
				status_q <= spread_ok ? ST_OK : ST_SPREAD_BIG;
			end else begin
				fix_q    <= 1'b0;
				status_q <= status_s1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign fix_ok    = fix_q;
	assign status    = status_q;

	a_fix_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (fix_q == (status_q == ST_OK)))
		else $error("fix flag and status disagree");

	a_extremes: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && check_s1) |-> (min_s1 <= max_s1))
		else $error("window extremes crossed");

	a_clear_only: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(fix_seen_q) |-> $past(q_pop && (q_kind == KIND_CLEAR)))
		else $error("tracker dropped its fix without a clear");

endmodule

/* design/gnss_altitude_stability_gate_unit.sv */
// gnss_altitude_stability_gate_unit: top level of the gnss fix qualifier with altitude stability gate
// holds the configuration registers; instantiates gasg_front, gasg_queue and gasg_back from gasg_pkg
//
//   channel | handshake                  | payload
//   --------+----------------------------+-----------------------------------------------
//   input   | in_valid / in_stall        | operation, now_ms, validity flags, ages,
//           |                            | sat_count, altitude_cm
//   output  | out_valid / out_stall      | fix_ok, status
//   config  | cfg_write_en               | cfg_index, cfg_data
//
// one transaction per cycle sustained while out_stall stays low; each input transaction passes the
// queue, the tracker stage and the spread check stage into the output register
// the tracker state is updated as each item is popped, so items follow back to back without bubbles
// in_stall rises only when the queue is full; out_stall backs up the result register, then
// the tracker stage, then the queue, each side stalling on its own
// reset clears handshake control, tracker state and configuration to their reset values
module gnss_altitude_stability_gate_unit #(
	parameter int TIME_BITS   = gasg_pkg::TIME_BITS_DEFAULT,
	parameter int QUEUE_DEPTH = gasg_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_write_en,
	input  logic [gasg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gasg_pkg::CFG_W-1:0]        cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic [gasg_pkg::NOW_W-1:0]        now_ms,
	input  logic                              location_valid,
	input  logic [gasg_pkg::AGE_W-1:0]        location_age_ms,
	input  logic                              altitude_valid,
	input  logic [gasg_pkg::AGE_W-1:0]        altitude_age_ms,
	input  logic                              sats_valid,
	input  logic [gasg_pkg::SATS_W-1:0]       sat_count,
	input  logic signed [gasg_pkg::ALT_W-1:0] altitude_cm,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              fix_ok,
	output logic [2:0]                        status
);
	import gasg_pkg::*;

	// queue word: kind, wrapped time, altitude
	localparam int QW = KIND_W + TIME_BITS + ALT_W;

	cfg_t cfg_q;

	logic                    q_full;
	logic                    q_push;
	item_kind_t              f_kind;
	logic [TIME_BITS-1:0]    f_now;
	logic signed [ALT_W-1:0] f_alt;
	logic [QW-1:0]           push_word;
	logic [QW-1:0]           pop_word;
	logic                    q_valid;
	logic                    q_pop;
	item_kind_t              b_kind;
	logic [TIME_BITS-1:0]    b_now;
	logic signed [ALT_W-1:0] b_alt;
	status_t                 b_status;

	// configuration registers; the user must write them only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_sats      <= MIN_SATS_RESET;
			cfg_q.warmup_ms     <= WARMUP_RESET;
			cfg_q.window_ms     <= WINDOW_RESET;
			cfg_q.max_spread_cm <= MAX_SPREAD_RESET;
			cfg_q.max_age_ms    <= MAX_AGE_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_MIN_SATS:   cfg_q.min_sats      <= cfg_data[SATS_W-1:0];
				REG_WARMUP:     cfg_q.warmup_ms     <= cfg_data[31:0];
				REG_WINDOW:     cfg_q.window_ms     <= cfg_data[31:0];
				REG_MAX_SPREAD: cfg_q.max_spread_cm <= cfg_data[SPREAD_W-1:0];
				REG_MAX_AGE:    cfg_q.max_age_ms    <= cfg_data[AGE_W-1:0];
				default: begin
					// unknown index, ignored
				end
			endcase
		end
	end

	// front: handshake and fix classification
	gasg_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.now_ms          (now_ms),
		.location_valid  (location_valid),
		.location_age_ms (location_age_ms),
		.altitude_valid  (altitude_valid),
		.altitude_age_ms (altitude_age_ms),
		.sats_valid      (sats_valid),
		.sat_count       (sat_count),
		.altitude_cm     (altitude_cm),
		.cfg             (cfg_q),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_kind          (f_kind),
		.q_now           (f_now),
		.q_alt           (f_alt)
	);

	assign push_word = {f_kind, f_now, f_alt};

	// decoupling queue between classification and tracking
	gasg_queue #(
		.DATA_W (QW),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_word),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (pop_word)
	);

	assign b_kind = item_kind_t'(pop_word[QW-1 -: KIND_W]);
	assign b_now  = pop_word[ALT_W +: TIME_BITS];
	assign b_alt  = pop_word[ALT_W-1:0];

	// back: tracker state, warm-up and window timing, spread check
	gasg_back #(
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_kind    (b_kind),
		.q_now     (b_now),
		.q_alt     (b_alt),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.fix_ok    (fix_ok),
		.status    (b_status)
	);

	assign status = b_status;

endmodule

/* test/gnss_altitude_stability_gate_unit_test.sv */
// gnss_altitude_stability_gate_unit_test: self-checking bench for the gnss fix stability gate
// drives directed and random fix transactions, predicts each result in-bench and compares it
// depends on gasg_pkg and gnss_altitude_stability_gate_unit
module gnss_altitude_stability_gate_unit_test;
	import gasg_pkg::*;

	// operation codes of the input transaction
	localparam logic OP_EVALUATE = 1'b0;
	localparam logic OP_CLEAR    = 1'b1;

	// an index past the last register, writes to it are dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam int PIPE_LATENCY   = 3;
	localparam int TIMEOUT_CYCLES = 200000;

	typedef struct {
		logic                    operation;
		logic [NOW_W-1:0]        now_ms;
		logic                    location_valid;
		logic [AGE_W-1:0]        location_age_ms;
		logic                    altitude_valid;
		logic [AGE_W-1:0]        altitude_age_ms;
		logic                    sats_valid;
		logic [SATS_W-1:0]       sat_count;
		logic signed [ALT_W-1:0] altitude_cm;
	} fix_item_t;

	typedef struct {
		logic    fix;
		status_t st;
	} gate_result_t;

	// clock, reset and block ports
	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_write_en;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic                    operation;
	logic [NOW_W-1:0]        now_ms;
	logic                    location_valid;
	logic [AGE_W-1:0]        location_age_ms;
	logic                    altitude_valid;
	logic [AGE_W-1:0]        altitude_age_ms;
	logic                    sats_valid;
	logic [SATS_W-1:0]       sat_count;
	logic signed [ALT_W-1:0] altitude_cm;
	logic                    out_valid;
	logic                    out_stall;
	logic                    fix_ok;
	logic [2:0]              status;

	// in-bench copy of the configuration registers
	logic [SATS_W-1:0]   cfg_min_sats   = MIN_SATS_RESET;
	logic [31:0]         cfg_warmup     = WARMUP_RESET;
	logic [31:0]         cfg_window     = WINDOW_RESET;
	logic [SPREAD_W-1:0] cfg_max_spread = MAX_SPREAD_RESET;
	logic [AGE_W-1:0]    cfg_max_age    = MAX_AGE_RESET;

	// in-bench copy of the stability tracker
	logic                    trk_seen      = 1'b0;
	logic [NOW_W-1:0]        trk_first     = '0;
	logic [NOW_W-1:0]        trk_win_start = '0;
	logic signed [ALT_W-1:0] trk_min       = ALT_TOP;
	logic signed [ALT_W-1:0] trk_max       = ALT_BOTTOM;

	gate_result_t pending_results[$];
	gate_result_t head_result;
	int           mismatches = 0;

	// idling control; the enable is shared by sender and receiver, the counters serve the receiver
	bit idle_en       = 1'b1;
	int rx_hold_left  = 0;
	int rx_burst_left = 0;

	// state of the well-formed random fix stream
	logic [NOW_W-1:0] stream_now;
	int               stream_base;
	int unsigned      stream_noise;
	int unsigned      stream_step_max;

	gnss_altitude_stability_gate_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.now_ms          (now_ms),
		.location_valid  (location_valid),
		.location_age_ms (location_age_ms),
		.altitude_valid  (altitude_valid),
		.altitude_age_ms (altitude_age_ms),
		.sats_valid      (sats_valid),
		.sat_count       (sat_count),
		.altitude_cm     (altitude_cm),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.fix_ok          (fix_ok),
		.status          (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case the block locks up
	initial begin
		#(TIMEOUT_CYCLES * 10);
		$display("FAIL gnss_altitude_stability_gate_unit");
		$finish;
	end

	// reset the in-bench tracker, as a clear transaction does
	function automatic void tracker_clear();
		trk_seen      = 1'b0;
		trk_first     = '0;
		trk_win_start = '0;
		trk_min       = ALT_TOP;
		trk_max       = ALT_BOTTOM;
	endfunction

	// expected gate verdict for one accepted transaction, advancing the tracker copy
	function automatic gate_result_t gate_predict(input fix_item_t it);
		logic              loc_ok;
		logic              alt_ok;
		logic [SATS_W-1:0] sats;
		logic [NOW_W-1:0]  elapsed;
		longint            spread;
		gate_result_t      r;
		loc_ok = it.location_valid && (it.location_age_ms <= cfg_max_age);
		alt_ok = it.altitude_valid && (it.altitude_age_ms <= cfg_max_age);
		sats   = it.sats_valid ? it.sat_count : '0;
		r      = '{fix: 1'b0, st: ST_OK};
		if (it.operation == OP_CLEAR) begin
			tracker_clear();
			r.st = ST_CLEARED;
		end else if (!loc_ok) begin
			r.st = ST_LOC_BAD;
		end else if (sats < BASIC_SATS || sats < cfg_min_sats) begin
			r.st = ST_FEW_SATS;
		end else if (!alt_ok) begin
			r.st = ST_ALT_BAD;
		end else begin
			// first plausible fix opens the warm-up and the window
			if (!trk_seen) begin
				trk_seen      = 1'b1;
				trk_first     = it.now_ms;
				trk_win_start = it.now_ms;
				trk_min       = ALT_TOP;
				trk_max       = ALT_BOTTOM;
			end
			elapsed = it.now_ms - trk_first;
			if (elapsed < cfg_warmup) begin
				r.st = ST_WARMING;
			end else begin
				elapsed = it.now_ms - trk_win_start;
				if (elapsed > cfg_window) begin
					trk_win_start = it.now_ms;
					trk_min       = ALT_TOP;
					trk_max       = ALT_BOTTOM;
				end
				if (it.altitude_cm < trk_min) trk_min = it.altitude_cm;
				if (it.altitude_cm > trk_max) trk_max = it.altitude_cm;
				spread = longint'(trk_max) - longint'(trk_min);
				if (spread <= longint'(cfg_max_spread)) begin
					r.fix = 1'b1;
					r.st  = ST_OK;
				end else begin
					r.st = ST_SPREAD_BIG;
				end
			end
		end
		return r;
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("%s", msg);
	endfunction

	// result checker: every output transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("%0t: unexpected result fix_ok %0b status %0d",
					$time, fix_ok, status));
			end else begin
				head_result = pending_results.pop_front();
				if (fix_ok !== head_result.fix || status !== head_result.st) begin
					note_mismatch($sformatf(
						"%0t: fix_ok exp %0b got %0b, status exp %0d got %0d",
						$time, head_result.fix, fix_ok, head_result.st, status));
				end
			end
		end
	end

	// receiver: random stall bursts, plus a long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				out_stall <= 1'b1;
				rx_hold_left--;
			end else if (rx_burst_left > 0) begin
				out_stall <= 1'b1;
				rx_burst_left--;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				rx_burst_left = $urandom_range(1, 4) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// offer one transaction, hold it until accepted, then log its expected result
	task automatic send_item(input fix_item_t it);
		int gap;
		@(negedge clk);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid        <= 1'b1;
		operation       <= it.operation;
		now_ms          <= it.now_ms;
		location_valid  <= it.location_valid;
		location_age_ms <= it.location_age_ms;
		altitude_valid  <= it.altitude_valid;
		altitude_age_ms <= it.altitude_age_ms;
		sats_valid      <= it.sats_valid;
		sat_count       <= it.sat_count;
		altitude_cm     <= it.altitude_cm;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(gate_predict(it));
	endtask

	// drop valid and hold off until every result is back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= val;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			REG_MIN_SATS:   cfg_min_sats   = val[SATS_W-1:0];
			REG_WARMUP:     cfg_warmup     = val;
			REG_WINDOW:     cfg_window     = val;
			REG_MAX_SPREAD: cfg_max_spread = val[SPREAD_W-1:0];
			REG_MAX_AGE:    cfg_max_age    = val[AGE_W-1:0];
			default: ;
		endcase
	endtask

	// registers only change with the block empty
	task automatic apply_config(input logic [SATS_W-1:0] mins, input logic [31:0] warm,
			input logic [31:0] win, input logic [SPREAD_W-1:0] spread,
			input logic [AGE_W-1:0] age);
		wait_drained();
		write_reg(REG_MIN_SATS, CFG_W'(mins));
		write_reg(REG_WARMUP, warm);
		write_reg(REG_WINDOW, win);
		write_reg(REG_MAX_SPREAD, CFG_W'(spread));
		write_reg(REG_MAX_AGE, CFG_W'(age));
	endtask

	// a fix that passes every plausibility check under the reset settings
	function automatic fix_item_t good_item(input logic [NOW_W-1:0] t,
			input logic signed [ALT_W-1:0] alt);
		fix_item_t it;
		it.operation       = OP_EVALUATE;
		it.now_ms          = t;
		it.location_valid  = 1'b1;
		it.location_age_ms = '0;
		it.altitude_valid  = 1'b1;
		it.altitude_age_ms = '0;
		it.sats_valid      = 1'b1;
		it.sat_count       = 6'd12;
		it.altitude_cm     = alt;
		return it;
	endfunction

	// every field uniform over its full width
	function automatic fix_item_t noise_item();
		fix_item_t it;
		it.operation       = 1'($urandom);
		it.now_ms          = $urandom;
		it.location_valid  = 1'($urandom);
		it.location_age_ms = 16'($urandom);
		it.altitude_valid  = 1'($urandom);
		it.altitude_age_ms = 16'($urandom);
		it.sats_valid      = 1'($urandom);
		it.sat_count       = 6'($urandom);
		it.altitude_cm     = 25'($urandom);
		return it;
	endfunction

	// steady receiver: rising time, altitude jitter round a base, now and then one bad check
	function automatic fix_item_t next_stream_item();
		fix_item_t it;
		int        alt;
		int        lo_sats;
		stream_now = stream_now + $urandom_range(0, stream_step_max);
		alt = stream_base + int'($urandom_range(0, 2 * stream_noise)) - int'(stream_noise);
		it  = good_item(stream_now, alt[ALT_W-1:0]);
		lo_sats = (cfg_min_sats > BASIC_SATS) ? int'(cfg_min_sats) : int'(BASIC_SATS);
		it.sat_count       = SATS_W'($urandom_range(lo_sats, 63));
		it.location_age_ms = AGE_W'($urandom_range(0, cfg_max_age));
		it.altitude_age_ms = AGE_W'($urandom_range(0, cfg_max_age));
		if ($urandom_range(0, 11) == 0) begin
			case ($urandom_range(0, 3))
				0: it.location_valid = 1'b0;
				1: begin
					if (cfg_max_age != '1)
						it.location_age_ms = AGE_W'($urandom_range(cfg_max_age + 1, 16'hFFFF));
					else
						it.location_valid = 1'b0;
				end
				2: begin
					if ($urandom_range(0, 1)) it.sats_valid = 1'b0;
					else it.sat_count = SATS_W'($urandom_range(0, lo_sats - 1));
				end
				default: begin
					if (cfg_max_age != '1 && $urandom_range(0, 1))
						it.altitude_age_ms = AGE_W'($urandom_range(cfg_max_age + 1, 16'hFFFF));
					else
						it.altitude_valid = 1'b0;
				end
			endcase
		end
		return it;
	endfunction

	// each failing check in priority order, ages at and past the limit
	task automatic test_check_order();
		fix_item_t it;
		it = noise_item();
		it.operation = OP_CLEAR;
		send_item(it);
		it = good_item(32'd500, 25'sd0);
		it.location_valid = 1'b0;
		send_item(it);
		it.location_valid  = 1'b1;
		it.location_age_ms = 16'hFFFF;
		send_item(it);
		// age on the limit still fresh, so the satellite check decides
		it.location_age_ms = MAX_AGE_RESET;
		it.sat_count       = 6'd3;
		send_item(it);
		it.sat_count  = 6'd63;
		it.sats_valid = 1'b0;
		send_item(it);
		it.sats_valid = 1'b1;
		it.sat_count  = MIN_SATS_RESET - 6'd1;
		send_item(it);
		it.sat_count      = MIN_SATS_RESET;
		it.altitude_valid = 1'b0;
		send_item(it);
		it.altitude_valid  = 1'b1;
		it.altitude_age_ms = MAX_AGE_RESET + 16'd1;
		send_item(it);
	endtask

	// warm-up edges, window spread edges, window restart, altitude extremes, time wrap
	task automatic test_warmup_and_window();
		fix_item_t it;
		it = good_item(32'd1000, 25'sd0);
		it.altitude_age_ms = MAX_AGE_RESET;
		send_item(it);
		send_item(good_item(32'd1000 + WARMUP_RESET - 1, 25'sd0));
		send_item(good_item(32'd1000 + WARMUP_RESET, 25'sd100));
		send_item(good_item(32'd10000, 25'sd100 + MAX_SPREAD_RESET));
		send_item(good_item(32'd11000, 25'sd101 + MAX_SPREAD_RESET));
		// window age exactly on the length keeps the window
		send_item(good_item(32'd9000 + WINDOW_RESET, 25'sd901));
		send_item(good_item(32'd9000 + WINDOW_RESET + 1, 25'sd901));
		send_item(good_item(32'd13001, ALT_TOP));
		send_item(good_item(32'd13001, ALT_BOTTOM));
		it = good_item(32'd0, 25'sd0);
		it.operation = OP_CLEAR;
		send_item(it);
		// warm-up measured across the wrap of the millisecond counter
		send_item(good_item(32'hFFFF_F000, -25'sd1000));
		send_item(good_item(32'h0000_1000, -25'sd1000));
		it = good_item('1, '1);
		it.operation       = OP_CLEAR;
		it.location_age_ms = '1;
		it.altitude_age_ms = '1;
		it.sat_count       = '1;
		send_item(it);
	endtask

	// every register at both ends of its range, and a write to an unused index
	task automatic test_register_extremes();
		fix_item_t it;
		apply_config('0, '0, '0, '0, '0);
		it = good_item(32'd100, 25'sd5);
		it.operation = OP_CLEAR;
		send_item(it);
		it.operation = OP_EVALUATE;
		it.sat_count = BASIC_SATS;
		send_item(it);
		it.altitude_cm = 25'sd6;
		send_item(it);
		it.now_ms = 32'd101;
		send_item(it);
		it.location_age_ms = 16'd1;
		send_item(it);
		it.location_age_ms = '0;
		it.sat_count       = BASIC_SATS - 6'd1;
		send_item(it);

		apply_config('1, '1, '1, '1, '1);
		it = good_item(32'd7, ALT_BOTTOM);
		it.operation = OP_CLEAR;
		send_item(it);
		it.operation       = OP_EVALUATE;
		it.sat_count       = 6'd62;
		it.location_age_ms = '1;
		it.altitude_age_ms = '1;
		send_item(it);
		it.sat_count = 6'd63;
		send_item(it);
		it.now_ms = 32'd7 + 32'hFFFF_FFFE;
		send_item(it);
		it.now_ms = 32'd7 + 32'hFFFF_FFFF;
		send_item(it);
		it.altitude_cm = ALT_TOP;
		send_item(it);

		// dropped write, settings must stay as they are
		wait_drained();
		write_reg(REG_UNUSED, '0);
		send_item(it);
	endtask

	// random settings per phase, each phase a cleared tracker and a stream of fixes
	task automatic test_random_settings(input int phases, input int per_phase);
		fix_item_t           it;
		logic [SATS_W-1:0]   mins;
		logic [31:0]         warm;
		logic [31:0]         win;
		logic [SPREAD_W-1:0] spread;
		logic [AGE_W-1:0]    age;
		int unsigned         pick;
		for (int p = 0; p < phases; p++) begin
			if ($urandom_range(0, 4) == 0) mins = $urandom_range(0, 1) ? 6'd63 : 6'd0;
			else mins = SATS_W'($urandom_range(0, 10));
			if ($urandom_range(0, 4) == 0) warm = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
			else warm = $urandom_range(0, 6000);
			if ($urandom_range(0, 4) == 0) win = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
			else win = $urandom_range(0, 5000);
			if ($urandom_range(0, 4) == 0) spread = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
			else spread = SPREAD_W'($urandom_range(0, 1500));
			if ($urandom_range(0, 4) == 0) age = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
			else age = AGE_W'($urandom_range(100, 4000));
			apply_config(mins, warm, win, spread, age);

			stream_now      = (p == 0) ? 32'hFFFF_E000 : $urandom;
			stream_base     = int'($urandom_range(0, 11000000)) - 1000000;
			stream_noise    = $urandom_range(0, 1000);
			stream_step_max = $urandom_range(0, 2000);
			it = next_stream_item();
			it.operation = OP_CLEAR;
			send_item(it);
			for (int n = 0; n < per_phase; n++) begin
				pick = $urandom_range(0, 99);
				if (pick <= 2) begin
					it = noise_item();
					it.operation = OP_CLEAR;
				end else if (pick <= 12) begin
					it = noise_item();
				end else begin
					it = next_stream_item();
				end
				send_item(it);
			end
		end
	endtask

	// receiver holds off long enough for the queue to fill and stall the input side
	task automatic test_receiver_backlog();
		rx_hold_left = 50;
		for (int n = 0; n < 30; n++) send_item(next_stream_item());
		wait_drained();
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_write_en    = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		in_valid        = 1'b0;
		operation       = OP_EVALUATE;
		now_ms          = '0;
		location_valid  = 1'b0;
		location_age_ms = '0;
		altitude_valid  = 1'b0;
		altitude_age_ms = '0;
		sats_valid      = 1'b0;
		sat_count       = '0;
		altitude_cm     = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_check_order();
		test_warmup_and_window();
		test_register_extremes();
		test_random_settings(6, 90);
		test_receiver_backlog();
		// closing stretch with no idling on either side
		idle_en = 1'b0;
		test_random_settings(1, 100);
		wait_drained();

		if (mismatches == 0) begin
			$display("PASS gnss_altitude_stability_gate_unit");
		end else begin
			$display("FAIL gnss_altitude_stability_gate_unit");
		end
		$finish;
	end

endmodule

/* sim.f */
design/gasg_pkg.sv
design/gasg_front.sv
design/gasg_queue.sv
design/gasg_back.sv
design/gnss_altitude_stability_gate_unit.sv
test/gnss_altitude_stability_gate_unit_test.sv
